/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must never hold outside reset.
`define CPPS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define CPPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// Antecedent implies consequent in the next cycle.
`define CPPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define CPPS_ASSERT_NEVER(label, clk, rst_n, cond)
`define CPPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CPPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/cpps_pkg.sv */
`default_nettype none
package cpps_pkg;

    // Fixed-point format of every state value
    localparam int FRAC = 16;

    // Angle reduction: magnitude of angle in Q30, one quotient bit per step
    localparam int RED_W     = 62 - FRAC;
    localparam int RED_STEPS = 30 - FRAC;
    localparam int R_W       = 36;
    localparam int XY_W      = 34;
    localparam int CORDIC_ITERS = 30;
    localparam int DIV_W     = 32 + FRAC;
    localparam int CNT_W     = 6;
    localparam int PC_W      = 5;
    localparam int UCODE_LEN = 25;

    localparam longint Q_ONE = 64'sd1 << FRAC;

    localparam logic signed [31:0] C_GRAVITY     = 32'((98 * Q_ONE + 5) / 10);
    localparam logic signed [31:0] C_POLE_ML     = 32'((Q_ONE + 10) / 20);
    localparam logic signed [31:0] C_POLE_LEN    = 32'((Q_ONE + 1) / 2);
    localparam logic signed [31:0] C_FOUR_THIRDS = 32'((8 * Q_ONE + 3) / 6);
    localparam logic signed [31:0] C_MP_TOT      = 32'((2 * Q_ONE + 11) / 22);
    localparam logic signed [31:0] C_INV_TOT     = 32'((20 * Q_ONE + 11) / 22);
    localparam logic signed [31:0] C_TAU         = 32'((Q_ONE + 25) / 50);

    localparam logic [RED_W-1:0]      TWO_PI_RED = RED_W'(64'd6746518852);
    localparam logic signed [R_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [R_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [R_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Configuration register indexes and reset values
    typedef enum logic [1:0] {
        REG_FORCE   = 2'd0,
        REG_POS_LIM = 2'd1,
        REG_ANG_LIM = 2'd2,
        REG_EP_LEN  = 2'd3
    } t_reg;

    localparam logic [30:0] RST_FORCE   = 31'd655360;
    localparam logic [30:0] RST_POS_LIM = 31'd157286;
    localparam logic [30:0] RST_ANG_LIM = 31'd13726;
    localparam logic [15:0] RST_EP_LEN  = 16'd500;

    typedef enum logic [1:0] {ALU_MUL, ALU_ADD, ALU_SUB, ALU_DIV} t_alu;

    typedef enum logic [4:0] {
        SRC_T1, SRC_T2, SRC_TEMP, SRC_NUM, SRC_THACC, SRC_XACC, SRC_S, SRC_C,
        SRC_POS, SRC_VEL, SRC_ANG, SRC_ANGV, SRC_FORCE,
        SRC_GRAV, SRC_POLE_ML, SRC_POLE_LEN, SRC_FOUR_THIRDS, SRC_MP_TOT,
        SRC_INV_TOT, SRC_TAU
    } t_src;

    typedef enum logic [3:0] {
        DST_T1, DST_T2, DST_TEMP, DST_NUM, DST_DEN, DST_XACC,
        DST_POS, DST_VEL, DST_ANG, DST_ANGV
    } t_dst;

    typedef struct packed {
        t_alu alu;
        t_src a;
        t_src b;
        t_dst d;
    } t_uop;

    typedef enum logic [3:0] {
        CMD_NOP, CMD_LOAD, CMD_RED, CMD_FOLD_A, CMD_FOLD_B, CMD_CORDIC,
        CMD_CORD_END, CMD_ALU, CMD_DIV_INIT, CMD_DIV_STEP, CMD_DIV_END,
        CMD_FIN_STEP, CMD_FIN_RST
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        t_uop             uop;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_FOLD_A, ST_FOLD_B, ST_CORDIC, ST_CORD_END,
        ST_UOP, ST_DIV, ST_DIV_END, ST_FIN
    } t_state;

    // Arctangent table, Q30, truncated
    function automatic logic signed [R_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [R_W-1:0] v;
        case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd7;
            5'd28: v = 36'sd3;
            5'd29: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Micro-program of the acceleration and Euler update
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = '{ALU_MUL, SRC_POLE_ML, SRC_ANGV, DST_T1};
            5'd1:  u = '{ALU_MUL, SRC_T1, SRC_ANGV, DST_T1};
            5'd2:  u = '{ALU_MUL, SRC_T1, SRC_S, DST_T1};
            5'd3:  u = '{ALU_ADD, SRC_FORCE, SRC_T1, DST_T1};
            5'd4:  u = '{ALU_MUL, SRC_T1, SRC_INV_TOT, DST_TEMP};
            5'd5:  u = '{ALU_MUL, SRC_GRAV, SRC_S, DST_T1};
            5'd6:  u = '{ALU_MUL, SRC_C, SRC_TEMP, DST_T2};
            5'd7:  u = '{ALU_SUB, SRC_T1, SRC_T2, DST_NUM};
            5'd8:  u = '{ALU_MUL, SRC_MP_TOT, SRC_C, DST_T1};
            5'd9:  u = '{ALU_MUL, SRC_T1, SRC_C, DST_T1};
            5'd10: u = '{ALU_SUB, SRC_FOUR_THIRDS, SRC_T1, DST_T1};
            5'd11: u = '{ALU_MUL, SRC_POLE_LEN, SRC_T1, DST_DEN};
            5'd12: u = '{ALU_DIV, SRC_NUM, SRC_T1, DST_T1};
            5'd13: u = '{ALU_MUL, SRC_POLE_ML, SRC_THACC, DST_T1};
            5'd14: u = '{ALU_MUL, SRC_T1, SRC_C, DST_T1};
            5'd15: u = '{ALU_MUL, SRC_T1, SRC_INV_TOT, DST_T1};
            5'd16: u = '{ALU_SUB, SRC_TEMP, SRC_T1, DST_XACC};
            5'd17: u = '{ALU_MUL, SRC_TAU, SRC_VEL, DST_T1};
            5'd18: u = '{ALU_ADD, SRC_POS, SRC_T1, DST_POS};
            5'd19: u = '{ALU_MUL, SRC_TAU, SRC_XACC, DST_T1};
            5'd20: u = '{ALU_ADD, SRC_VEL, SRC_T1, DST_VEL};
            5'd21: u = '{ALU_MUL, SRC_TAU, SRC_ANGV, DST_T1};
            5'd22: u = '{ALU_ADD, SRC_ANG, SRC_T1, DST_ANG};
            5'd23: u = '{ALU_MUL, SRC_TAU, SRC_THACC, DST_T1};
            5'd24: u = '{ALU_ADD, SRC_ANGV, SRC_T1, DST_ANGV};
            default: u = '{ALU_ADD, SRC_T1, SRC_T2, DST_T2};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

/* src/cpps_if.sv */
`default_nettype none
// Input request channel
interface cpps_in_if;
    logic valid;
    logic ready;
    logic op;
    logic push_right;
    modport source (output valid, output op, output push_right, input ready);
    modport sink (input valid, input op, input push_right, output ready);
endinterface

// Result channel
interface cpps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cart_position;
    logic signed [31:0] cart_velocity;
    logic signed [31:0] pole_angle;
    logic signed [31:0] pole_angular_velocity;
    logic               reward;
    logic               done_res;
    modport source (output valid, output cart_position, output cart_velocity,
                    output pole_angle, output pole_angular_velocity,
                    output reward, output done_res, input ready);
    modport sink (input valid, input cart_position, input cart_velocity,
                  input pole_angle, input pole_angular_velocity,
                  input reward, input done_res, output ready);
endinterface

// Configuration write channel
interface cpps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/cart_pole_physics_step_top.sv */
`default_nettype none
// Cart-pole environment step engine, Q16.16. A request with op=0 restarts
// the episode and returns the zero observation; op=1 applies +/- force and
// advances one Euler step, returning the new state, reward and done. One
// request at a time: a step runs angle reduction, CORDIC, a 25-entry
// micro-program on one shared multiplier and a bit-serial divider. The
// result waits in an output register, so the next request is accepted
// while it is pending. Configuration writes are taken at any time but
// belong in idle periods.
module cart_pole_physics_step_top (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    cpps_in_if.sink    i_in,
    cpps_cfg_if.sink   i_cfg,
    cpps_out_if.source o_out
);

    cpps_pkg::t_cmd    cmd;
    cpps_pkg::t_status status;

    cpps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cpps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_push_right (i_in.push_right),
        .cfg          (i_cfg),
        .res          (o_out)
    );

endmodule
`default_nettype wire

/* src/cpps_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"
module cpps_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_op,
    output logic                  o_in_ready,
    input  wire cpps_pkg::t_status i_status,
    output cpps_pkg::t_cmd        o_cmd
);

    cpps_pkg::t_state r_state, n_state;
    logic [cpps_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [cpps_pkg::PC_W-1:0]  r_pc, n_pc;
    logic r_step, n_step;
    cpps_pkg::t_uop uop;

    assign uop = cpps_pkg::ucode(r_pc);

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpps_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_step  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
            r_step  <= n_step;
        end
    end

    // Sequence a step request through reduction, CORDIC, micro-program, divide; a restart goes straight to finish
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pc       = r_pc;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd.kind = cpps_pkg::CMD_NOP;
        o_cmd.uop  = uop;
        o_cmd.idx  = r_cnt;
        case (r_state)
            cpps_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_step = i_in_op;
                    if (i_in_op) begin
                        o_cmd.kind = cpps_pkg::CMD_LOAD;
                        n_cnt      = cpps_pkg::CNT_W'(cpps_pkg::RED_STEPS - 1);
                        n_state    = cpps_pkg::ST_RED;
                    end else begin
                        n_state = cpps_pkg::ST_FIN;
                    end
                end
            end
            cpps_pkg::ST_RED: begin
                o_cmd.kind = cpps_pkg::CMD_RED;
                if (r_cnt == '0) begin
                    n_state = cpps_pkg::ST_FOLD_A;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            cpps_pkg::ST_FOLD_A: begin
                o_cmd.kind = cpps_pkg::CMD_FOLD_A;
                n_state    = cpps_pkg::ST_FOLD_B;
            end
            cpps_pkg::ST_FOLD_B: begin
                o_cmd.kind = cpps_pkg::CMD_FOLD_B;
                n_cnt      = '0;
                n_state    = cpps_pkg::ST_CORDIC;
            end
            cpps_pkg::ST_CORDIC: begin
                o_cmd.kind = cpps_pkg::CMD_CORDIC;
                if (r_cnt == cpps_pkg::CNT_W'(cpps_pkg::CORDIC_ITERS - 1)) begin
                    n_state = cpps_pkg::ST_CORD_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cpps_pkg::ST_CORD_END: begin
                o_cmd.kind = cpps_pkg::CMD_CORD_END;
                n_pc       = '0;
                n_state    = cpps_pkg::ST_UOP;
            end
            cpps_pkg::ST_UOP: begin
                if (uop.alu == cpps_pkg::ALU_DIV) begin
                    o_cmd.kind = cpps_pkg::CMD_DIV_INIT;
                    n_cnt      = cpps_pkg::CNT_W'(cpps_pkg::DIV_W - 1);
                    n_state    = cpps_pkg::ST_DIV;
                end else begin
                    o_cmd.kind = cpps_pkg::CMD_ALU;
                    if (r_pc == cpps_pkg::PC_W'(cpps_pkg::UCODE_LEN - 1)) begin
                        n_state = cpps_pkg::ST_FIN;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            cpps_pkg::ST_DIV: begin
                o_cmd.kind = cpps_pkg::CMD_DIV_STEP;
                if (r_cnt == '0) begin
                    n_state = cpps_pkg::ST_DIV_END;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            cpps_pkg::ST_DIV_END: begin
                o_cmd.kind = cpps_pkg::CMD_DIV_END;
                n_pc       = r_pc + 1'b1;
                n_state    = cpps_pkg::ST_UOP;
            end
            cpps_pkg::ST_FIN: begin
                if (!i_status.out_full) begin
                    o_cmd.kind = r_step ? cpps_pkg::CMD_FIN_STEP : cpps_pkg::CMD_FIN_RST;
                    n_state    = cpps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cpps_pkg::ST_IDLE;
            end
        endcase
    end

    `CPPS_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != cpps_pkg::ST_IDLE)
    `CPPS_ASSERT_IMPL(a_cordic_idx_range, i_clk, i_rst_n, r_state == cpps_pkg::ST_CORDIC, r_cnt < cpps_pkg::CNT_W'(cpps_pkg::CORDIC_ITERS))
    `CPPS_ASSERT_NEXT(a_div_follows_init, i_clk, i_rst_n, o_cmd.kind == cpps_pkg::CMD_DIV_INIT, r_state == cpps_pkg::ST_DIV)

endmodule
`default_nettype wire

/* src/cpps_dp.sv */
`default_nettype none
`include "assert_macros.svh"
module cpps_dp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire cpps_pkg::t_cmd i_cmd,
    output cpps_pkg::t_status o_status,
    input  wire logic        i_push_right,
    cpps_cfg_if.sink         cfg,
    cpps_out_if.source       res
);

    // Configuration
    logic [30:0] r_force_mag, r_pos_lim, r_ang_lim;
    logic [15:0] r_ep_len;

    // Physical state and scratch registers
    logic signed [31:0] r_pos, r_vel, r_ang, r_angv;
    logic [15:0]        r_steps;
    logic signed [31:0] r_force, r_t1, r_t2, r_temp, r_num, r_den, r_thacc, r_xacc;
    logic signed [31:0] r_s, r_c;

    // Angle reduction and CORDIC
    logic [cpps_pkg::RED_W-1:0]     r_rmag;
    logic                           r_rneg;
    logic signed [cpps_pkg::R_W-1:0]  r_z;
    logic                           r_flip;
    logic signed [cpps_pkg::XY_W-1:0] r_x, r_y;

    // Divider
    logic [cpps_pkg::DIV_W-1:0] r_dq;
    logic [32:0]                r_rem;
    logic [31:0]                r_dmag;
    logic                       r_dneg;

    // Result register
    logic               r_out_valid;
    logic signed [31:0] r_o_pos, r_o_vel, r_o_ang, r_o_angv;
    logic               r_o_reward, r_o_done;

    logic signed [31:0] opa, opb, alu_res;
    logic signed [63:0] prod;
    logic [cpps_pkg::RED_W-1:0] red_sub;
    logic signed [cpps_pkg::R_W-1:0] z_fa, z_fb;
    logic signed [cpps_pkg::XY_W-1:0] dx, dy, x_fin, y_fin, y_sh, x_sh;
    logic [32:0] rem_sh;
    logic [cpps_pkg::DIV_W:0] q_signed_mag;
    logic signed [63:0] q_val;
    logic [32:0] ang_abs, num_abs, den_abs, pos_abs, ang_n_abs;
    logic [15:0] steps_n;
    logic signed [31:0] den_g;

    assign cfg.ready = 1'b1;
    assign o_status.out_full = r_out_valid;

    // Select ALU operand
    function automatic logic signed [31:0] pick(
        input cpps_pkg::t_src s,
        input logic signed [31:0] t1, t2, temp, num, thacc, xacc, sv, cv,
        input logic signed [31:0] pos, vel, ang, angv, frc
    );
        logic signed [31:0] v;
        case (s)
            cpps_pkg::SRC_T1:          v = t1;
            cpps_pkg::SRC_T2:          v = t2;
            cpps_pkg::SRC_TEMP:        v = temp;
            cpps_pkg::SRC_NUM:         v = num;
            cpps_pkg::SRC_THACC:       v = thacc;
            cpps_pkg::SRC_XACC:        v = xacc;
            cpps_pkg::SRC_S:           v = sv;
            cpps_pkg::SRC_C:           v = cv;
            cpps_pkg::SRC_POS:         v = pos;
            cpps_pkg::SRC_VEL:         v = vel;
            cpps_pkg::SRC_ANG:         v = ang;
            cpps_pkg::SRC_ANGV:        v = angv;
            cpps_pkg::SRC_FORCE:       v = frc;
            cpps_pkg::SRC_GRAV:        v = cpps_pkg::C_GRAVITY;
            cpps_pkg::SRC_POLE_ML:     v = cpps_pkg::C_POLE_ML;
            cpps_pkg::SRC_POLE_LEN:    v = cpps_pkg::C_POLE_LEN;
            cpps_pkg::SRC_FOUR_THIRDS: v = cpps_pkg::C_FOUR_THIRDS;
            cpps_pkg::SRC_MP_TOT:      v = cpps_pkg::C_MP_TOT;
            cpps_pkg::SRC_INV_TOT:     v = cpps_pkg::C_INV_TOT;
            cpps_pkg::SRC_TAU:         v = cpps_pkg::C_TAU;
            default:                   v = '0;
        endcase
        return v;
    endfunction

    // Shared multiply / add / subtract with floor shift and saturation
    always_comb begin
        opa  = pick(i_cmd.uop.a, r_t1, r_t2, r_temp, r_num, r_thacc, r_xacc, r_s, r_c,
                    r_pos, r_vel, r_ang, r_angv, r_force);
        opb  = pick(i_cmd.uop.b, r_t1, r_t2, r_temp, r_num, r_thacc, r_xacc, r_s, r_c,
                    r_pos, r_vel, r_ang, r_angv, r_force);
        prod = opa * opb;
        case (i_cmd.uop.alu)
            cpps_pkg::ALU_MUL: alu_res = cpps_pkg::sat32(prod >>> cpps_pkg::FRAC);
            cpps_pkg::ALU_ADD: alu_res = cpps_pkg::sat32(64'(opa) + 64'(opb));
            cpps_pkg::ALU_SUB: alu_res = cpps_pkg::sat32(64'(opa) - 64'(opb));
            default:           alu_res = '0;
        endcase
    end

    // Angle reduction, folding and CORDIC helpers
    always_comb begin
        ang_abs = r_ang[31] ? 33'(-64'(r_ang)) : 33'(r_ang);
        red_sub = cpps_pkg::TWO_PI_RED << i_cmd.idx;
        z_fa    = r_rneg ? -cpps_pkg::R_W'(r_rmag) : cpps_pkg::R_W'(r_rmag);
        if (z_fa > cpps_pkg::PI_Q30) begin
            z_fa = z_fa - cpps_pkg::TWO_PI_Q30;
        end else if (z_fa < -cpps_pkg::PI_Q30) begin
            z_fa = z_fa + cpps_pkg::TWO_PI_Q30;
        end
        z_fb = r_z;
        if (r_z > cpps_pkg::HALF_PI_Q30) begin
            z_fb = r_z - cpps_pkg::PI_Q30;
        end else if (r_z < -cpps_pkg::HALF_PI_Q30) begin
            z_fb = r_z + cpps_pkg::PI_Q30;
        end
        dx    = r_y >>> i_cmd.idx[4:0];
        dy    = r_x >>> i_cmd.idx[4:0];
        x_fin = r_flip ? -r_x : r_x;
        y_fin = r_flip ? -r_y : r_y;
        x_sh  = x_fin >>> (30 - cpps_pkg::FRAC);
        y_sh  = y_fin >>> (30 - cpps_pkg::FRAC);
    end

    // Divider helpers
    always_comb begin
        num_abs = r_num[31] ? 33'(-64'(r_num)) : 33'(r_num);
        den_g   = (r_den == '0) ? 32'sd1 : r_den;
        den_abs = den_g[31] ? 33'(-64'(den_g)) : 33'(den_g);
        rem_sh  = {r_rem[31:0], r_dq[cpps_pkg::DIV_W-1]};
        q_signed_mag = {1'b0, r_dq};
        q_val   = r_dneg ? -64'(q_signed_mag) : 64'(q_signed_mag);
    end

    // Step counter and end-of-episode checks
    always_comb begin
        steps_n   = (r_steps == 16'hffff) ? r_steps : r_steps + 1'b1;
        pos_abs   = r_pos[31] ? 33'(-64'(r_pos)) : 33'(r_pos);
        ang_n_abs = ang_abs;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_mag <= cpps_pkg::RST_FORCE;
            r_pos_lim   <= cpps_pkg::RST_POS_LIM;
            r_ang_lim   <= cpps_pkg::RST_ANG_LIM;
            r_ep_len    <= cpps_pkg::RST_EP_LEN;
        end else if (cfg.valid) begin
            case (cpps_pkg::t_reg'(cfg.index))
                cpps_pkg::REG_FORCE:   r_force_mag <= cfg.data[30:0];
                cpps_pkg::REG_POS_LIM: r_pos_lim   <= cfg.data[30:0];
                cpps_pkg::REG_ANG_LIM: r_ang_lim   <= cfg.data[30:0];
                cpps_pkg::REG_EP_LEN:  r_ep_len    <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Physical state: clear on reset and restart, update from the ALU, count steps on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vel   <= '0;
            r_ang   <= '0;
            r_angv  <= '0;
            r_steps <= '0;
        end else if (i_cmd.kind == cpps_pkg::CMD_FIN_RST) begin
            r_pos   <= '0;
            r_vel   <= '0;
            r_ang   <= '0;
            r_angv  <= '0;
            r_steps <= '0;
        end else if (i_cmd.kind == cpps_pkg::CMD_FIN_STEP) begin
            r_steps <= steps_n;
        end else if (i_cmd.kind == cpps_pkg::CMD_ALU) begin
            case (i_cmd.uop.d)
                cpps_pkg::DST_POS:  r_pos  <= alu_res;
                cpps_pkg::DST_VEL:  r_vel  <= alu_res;
                cpps_pkg::DST_ANG:  r_ang  <= alu_res;
                cpps_pkg::DST_ANGV: r_angv <= alu_res;
                default: ;
            endcase
        end
    end

    // Scratch, reduction, CORDIC and divider registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.kind)
            cpps_pkg::CMD_LOAD: begin
                r_force <= i_push_right ? $signed({1'b0, r_force_mag})
                                        : -$signed({1'b0, r_force_mag});
                r_rmag  <= cpps_pkg::RED_W'(ang_abs) << (30 - cpps_pkg::FRAC);
                r_rneg  <= r_ang[31];
            end
            cpps_pkg::CMD_RED: begin
                if (r_rmag >= red_sub) begin
                    r_rmag <= r_rmag - red_sub;
                end
            end
            cpps_pkg::CMD_FOLD_A: begin
                r_z <= z_fa;
            end
            cpps_pkg::CMD_FOLD_B: begin
                r_z    <= z_fb;
                r_flip <= (r_z > cpps_pkg::HALF_PI_Q30) || (r_z < -cpps_pkg::HALF_PI_Q30);
                r_x    <= cpps_pkg::CORDIC_GAIN;
                r_y    <= '0;
            end
            cpps_pkg::CMD_CORDIC: begin
                if (!r_z[cpps_pkg::R_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - cpps_pkg::atan_q30(i_cmd.idx[4:0]);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + cpps_pkg::atan_q30(i_cmd.idx[4:0]);
                end
            end
            cpps_pkg::CMD_CORD_END: begin
                r_s <= y_sh[31:0];
                r_c <= x_sh[31:0];
            end
            cpps_pkg::CMD_ALU: begin
                case (i_cmd.uop.d)
                    cpps_pkg::DST_T1:   r_t1   <= alu_res;
                    cpps_pkg::DST_T2:   r_t2   <= alu_res;
                    cpps_pkg::DST_TEMP: r_temp <= alu_res;
                    cpps_pkg::DST_NUM:  r_num  <= alu_res;
                    cpps_pkg::DST_DEN:  r_den  <= alu_res;
                    cpps_pkg::DST_XACC: r_xacc <= alu_res;
                    default: ;
                endcase
            end
            cpps_pkg::CMD_DIV_INIT: begin
                r_dq   <= cpps_pkg::DIV_W'(num_abs) << cpps_pkg::FRAC;
                r_rem  <= '0;
                r_dmag <= den_abs[31:0];
                r_dneg <= r_num[31] ^ den_g[31];
            end
            cpps_pkg::CMD_DIV_STEP: begin
                if (rem_sh >= {1'b0, r_dmag}) begin
                    r_rem <= rem_sh - {1'b0, r_dmag};
                    r_dq  <= {r_dq[cpps_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_dq  <= {r_dq[cpps_pkg::DIV_W-2:0], 1'b0};
                end
            end
            cpps_pkg::CMD_DIV_END: begin
                r_thacc <= cpps_pkg::sat32(q_val);
            end
            default: ;
        endcase
    end

    // Result register: load on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.kind == cpps_pkg::CMD_FIN_STEP ||
                     i_cmd.kind == cpps_pkg::CMD_FIN_RST) begin
            r_out_valid <= 1'b1;
        end else if (res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.kind == cpps_pkg::CMD_FIN_STEP) begin
            r_o_pos    <= r_pos;
            r_o_vel    <= r_vel;
            r_o_ang    <= r_ang;
            r_o_angv   <= r_angv;
            r_o_reward <= 1'b1;
            r_o_done   <= (pos_abs > {2'b0, r_pos_lim}) ||
                          (ang_n_abs > {2'b0, r_ang_lim}) ||
                          (steps_n >= r_ep_len);
        end else if (i_cmd.kind == cpps_pkg::CMD_FIN_RST) begin
            r_o_pos    <= '0;
            r_o_vel    <= '0;
            r_o_ang    <= '0;
            r_o_angv   <= '0;
            r_o_reward <= 1'b0;
            r_o_done   <= 1'b0;
        end
    end

    assign res.valid                 = r_out_valid;
    assign res.cart_position         = r_o_pos;
    assign res.cart_velocity         = r_o_vel;
    assign res.pole_angle            = r_o_ang;
    assign res.pole_angular_velocity = r_o_angv;
    assign res.reward                = r_o_reward;
    assign res.done_res              = r_o_done;

    `CPPS_ASSERT_NEVER(a_fin_into_full, i_clk, i_rst_n, r_out_valid && (i_cmd.kind == cpps_pkg::CMD_FIN_STEP || i_cmd.kind == cpps_pkg::CMD_FIN_RST))
    `CPPS_ASSERT_NEVER(a_div_zero, i_clk, i_rst_n, (i_cmd.kind == cpps_pkg::CMD_DIV_STEP) && (r_dmag == '0))
    `CPPS_ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n, i_cmd.kind == cpps_pkg::CMD_FIN_STEP, r_out_valid && r_o_reward)

endmodule
`default_nettype wire
